[sv/gpioregs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO register block package
// Pin count, register word map, payload and decode types, reset tables.
// ----------------------------------------------------------------------------
package gpioregs_pkg;

    localparam int PIN_COUNT   = 54;
    localparam int FSEL_WORDS  = (PIN_COUNT + 9) / 10;
    localparam int FSEL_IDX_W  = $clog2(FSEL_WORDS);
    localparam int HI_PINS     = PIN_COUNT - 32;

    localparam logic [5:0] A_FSEL_LAST = 6'(FSEL_WORDS - 1);
    localparam logic [5:0] A_SET0  = 6'd7;
    localparam logic [5:0] A_SET1  = 6'd8;
    localparam logic [5:0] A_CLR0  = 6'd10;
    localparam logic [5:0] A_CLR1  = 6'd11;
    localparam logic [5:0] A_LEV0  = 6'd13;
    localparam logic [5:0] A_LEV1  = 6'd14;
    localparam logic [5:0] A_PULL  = 6'd37;
    localparam logic [5:0] A_PCLK0 = 6'd38;
    localparam logic [5:0] A_PCLK1 = 6'd39;

    localparam logic       MODE_READ  = 1'b0;
    localparam logic       MODE_WRITE = 1'b1;

    localparam logic [2:0] FSEL_OUTPUT = 3'd1;
    localparam logic [1:0] PULL_NONE   = 2'd0;
    localparam logic [1:0] PULL_DOWN   = 2'd1;
    localparam logic [1:0] PULL_UP     = 2'd2;

    typedef struct packed {
        logic                 mode;
        logic [5:0]           word_address;
        logic [31:0]          write_data;
        logic [PIN_COUNT-1:0] pad_levels;
    } t_cmd;

    typedef struct packed {
        logic [31:0]          read_data;
        logic                 access_error;
        logic [PIN_COUNT-1:0] drive_levels;
        logic [PIN_COUNT-1:0] output_enables;
        logic [PIN_COUNT-1:0] pull_up_pins;
        logic [PIN_COUNT-1:0] pull_down_pins;
    } t_rsp;

    typedef struct packed {
        logic fsel;
        logic set;
        logic clr;
        logic lev;
        logic pull;
        logic pclk;
        logic bank;
        logic error;
    } t_dec;

    function automatic logic [1:0] pull_reset_code(input int pin);
        logic [1:0] code;
        if (pin <= 8)       code = PULL_UP;
        else if (pin <= 27) code = PULL_DOWN;
        else if (pin <= 29) code = PULL_NONE;
        else if (pin <= 33) code = PULL_DOWN;
        else if (pin <= 36) code = PULL_UP;
        else if (pin <= 43) code = PULL_DOWN;
        else if (pin <= 45) code = PULL_NONE;
        else if (pin <= 53) code = PULL_UP;
        else                code = PULL_NONE;
        return code;
    endfunction

    function automatic logic [PIN_COUNT-1:0][1:0] pull_reset_table();
        logic [PIN_COUNT-1:0][1:0] t;
        for (int n = 0; n < PIN_COUNT; n++) begin
            t[n] = pull_reset_code(n);
        end
        return t;
    endfunction

    localparam logic [PIN_COUNT-1:0][1:0] PULL_RESET = pull_reset_table();

    function automatic logic [29:0] fsel_word_mask(input logic [FSEL_IDX_W-1:0] idx);
        logic [29:0] m;
        m = '0;
        for (int k = 0; k < 10; k++) begin
            if (int'(idx) * 10 + k < PIN_COUNT) begin
                m[3*k +: 3] = 3'b111;
            end
        end
        return m;
    endfunction

endpackage

[sv/gpioregs_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO register address decoder
// Maps a word address to its register group, bank and error flag.
// ----------------------------------------------------------------------------
module gpioregs_decode
    import gpioregs_pkg::*;
(
    input  logic [5:0] i_word_address,
    output t_dec       o_dec
);

    always_comb begin
        o_dec = '0;
        unique case (i_word_address) inside
            [6'd0:A_FSEL_LAST]: begin
                o_dec.fsel = 1'b1;
            end
            A_SET0, A_SET1: begin
                o_dec.set  = 1'b1;
                o_dec.bank = (i_word_address == A_SET1);
            end
            A_CLR0, A_CLR1: begin
                o_dec.clr  = 1'b1;
                o_dec.bank = (i_word_address == A_CLR1);
            end
            A_LEV0, A_LEV1: begin
                o_dec.lev  = 1'b1;
                o_dec.bank = (i_word_address == A_LEV1);
            end
            A_PULL: begin
                o_dec.pull = 1'b1;
            end
            A_PCLK0, A_PCLK1: begin
                o_dec.pclk = 1'b1;
                o_dec.bank = (i_word_address == A_PCLK1);
            end
            default: begin
                o_dec.error = 1'b1;
            end
        endcase
    end

endmodule

[sv/gpio_pin_controller_registers_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO pin controller register block
// Function selects, output latch set/clear, pad level read, pull control.
//
//   channel   strobe    payload    notes
//   command   i_start   i_cmd      taken when i_start && !o_busy
//   result    o_done    o_result   one cycle, no back-pressure
//
// One transaction per cycle. The accepting edge loads the command register;
// the result register then takes decode/update in step with o_done.
// o_busy is always low. Synchronous active-low reset loads the default
// pull table and clears selects, latch, pull code and pull clock words.
// ----------------------------------------------------------------------------
module gpio_pin_controller_registers_core
    import gpioregs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_cmd i_cmd,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_result
);

    logic                      r_cmd_valid;
    t_cmd                      r_cmd;
    logic                      r_done;
    t_rsp                      r_rsp;

    logic [29:0]               r_fsel [FSEL_WORDS];
    logic [PIN_COUNT-1:0]      r_latch;
    logic [1:0]                r_pull_code;
    logic [31:0]               r_pclk0;
    logic [HI_PINS-1:0]        r_pclk1;
    logic [PIN_COUNT-1:0][1:0] r_pull;

    logic [29:0]               n_fsel [FSEL_WORDS];
    logic [PIN_COUNT-1:0]      n_latch;
    logic [1:0]                n_pull_code;
    logic [31:0]               n_pclk0;
    logic [HI_PINS-1:0]        n_pclk1;
    logic [PIN_COUNT-1:0][1:0] n_pull;
    t_rsp                      n_rsp;

    t_dec                      dec;
    logic                      wr;
    logic [FSEL_IDX_W-1:0]     fidx;
    logic [63:0]               bank_bits;
    logic [63:0]               pads_wide;
    logic [31:0]               rd;

    gpioregs_decode u_decode (
        .i_word_address (r_cmd.word_address),
        .o_dec          (dec)
    );

    assign o_busy   = 1'b0;
    assign o_done   = r_done;
    assign o_result = r_rsp;

    assign wr        = r_cmd_valid && (r_cmd.mode == MODE_WRITE);
    assign fidx      = r_cmd.word_address[FSEL_IDX_W-1:0];
    assign bank_bits = dec.bank ? {r_cmd.write_data, 32'b0} : {32'b0, r_cmd.write_data};
    assign pads_wide = {{(64 - PIN_COUNT){1'b0}}, r_cmd.pad_levels};

    always_comb begin
        n_fsel      = r_fsel;
        n_latch     = r_latch;
        n_pull_code = r_pull_code;
        n_pclk0     = r_pclk0;
        n_pclk1     = r_pclk1;
        n_pull      = r_pull;
        rd          = '0;

        if (dec.fsel) begin
            if (wr) begin
                n_fsel[fidx] = r_cmd.write_data[29:0] & fsel_word_mask(fidx);
            end
            rd = {2'b0, r_fsel[fidx]};
        end
        if (dec.set && wr) begin
            n_latch = r_latch | bank_bits[PIN_COUNT-1:0];
        end
        if (dec.clr && wr) begin
            n_latch = r_latch & ~bank_bits[PIN_COUNT-1:0];
        end
        if (dec.lev) begin
            rd = dec.bank ? pads_wide[63:32] : pads_wide[31:0];
        end
        if (dec.pull) begin
            if (wr) begin
                n_pull_code = r_cmd.write_data[1:0];
            end
            rd = {30'b0, r_pull_code};
        end
        if (dec.pclk) begin
            if (wr) begin
                if (dec.bank) begin
                    n_pclk1 = r_cmd.write_data[HI_PINS-1:0];
                end else begin
                    n_pclk0 = r_cmd.write_data;
                end
                for (int n = 0; n < PIN_COUNT; n++) begin
                    if (bank_bits[n]) begin
                        n_pull[n] = r_pull_code;
                    end
                end
            end
            rd = dec.bank ? {{(32 - HI_PINS){1'b0}}, r_pclk1} : r_pclk0;
        end

        if (r_cmd.mode == MODE_WRITE) begin
            rd = '0;
        end

        n_rsp.read_data    = rd;
        n_rsp.access_error = dec.error;
        n_rsp.drive_levels = n_latch;
        for (int n = 0; n < PIN_COUNT; n++) begin
            n_rsp.output_enables[n] = (n_fsel[n / 10][3 * (n % 10) +: 3] == FSEL_OUTPUT);
            n_rsp.pull_up_pins[n]   = (n_pull[n] == PULL_UP);
            n_rsp.pull_down_pins[n] = (n_pull[n] == PULL_DOWN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_done      <= 1'b0;
            r_latch     <= '0;
            r_pull_code <= PULL_NONE;
            r_pclk0     <= '0;
            r_pclk1     <= '0;
            r_pull      <= PULL_RESET;
            for (int w = 0; w < FSEL_WORDS; w++) begin
                r_fsel[w] <= '0;
            end
        end else begin
            r_cmd_valid <= i_start && !o_busy;
            r_done      <= r_cmd_valid;
            if (r_cmd_valid) begin
                r_fsel      <= n_fsel;
                r_latch     <= n_latch;
                r_pull_code <= n_pull_code;
                r_pclk0     <= n_pclk0;
                r_pclk1     <= n_pclk1;
                r_pull      <= n_pull;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_cmd <= i_cmd;
        end
        if (r_cmd_valid) begin
            r_rsp <= n_rsp;
        end
    end

endmodule
